// ----- rtl/core/fnm_pkg.sv -----
// Shared types and constants of the four-neighbour mean filter.
package fnm_pkg;

  localparam int SAMPLE_W = 8;
  localparam int ROW_W = 10;
  localparam int COL_W = 12;

  localparam int CFG_DIM_W = 11;
  localparam int CFG_CH_W = 3;
  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;

  localparam int DIM_MIN = 3;
  localparam int CH_MIN = 1;
  localparam logic [CFG_DIM_W-1:0] WIDTH_RESET = 11'd640;
  localparam logic [CFG_DIM_W-1:0] HEIGHT_RESET = 11'd480;
  localparam logic [CFG_CH_W-1:0] CHANNELS_RESET = 3'd1;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = 2;
  localparam int FIFO_CNT_W = 3;

  typedef enum logic [1:0] {
    REG_WIDTH    = 2'd0,
    REG_HEIGHT   = 2'd1,
    REG_CHANNELS = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] out_value;
    logic [ROW_W-1:0]    out_row;
    logic [COL_W-1:0]    out_col;
    logic                out_last;
  } result_t;

endpackage

// ----- rtl/core/fnm_stream_if.sv -----
// Valid/ready stream interfaces for the sample input and the result output.
interface fnm_sample_if import fnm_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface fnm_result_if import fnm_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] out_value;
  logic [ROW_W-1:0]    out_row;
  logic [COL_W-1:0]    out_col;
  logic                out_last;

  modport source (output valid, output out_value, output out_row, output out_col,
                  output out_last, input ready);
  modport sink (input valid, input out_value, input out_row, input out_col,
                input out_last, output ready);
endinterface

// ----- rtl/core/fnm_ram.sv -----
// Generic RAM with one write port and two registered read ports.
module fnm_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH = 256,
  localparam int AddrW = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AddrW-1:0]  waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [AddrW-1:0]  raddr_a,
  input  logic [AddrW-1:0]  raddr_b,
  output logic [DATA_W-1:0] rdata_a,
  output logic [DATA_W-1:0] rdata_b
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

// ----- rtl/core/four_neighbour_mean_filter.sv -----
// Four-neighbour mean filter over a raster-order stream of interleaved image bytes.
//
// Usage: image bytes enter on the samples channel, one byte per word, in raster
// order with the channels of a pixel interleaved. Each accepted word at row r,
// byte column c produces the result word for row r-1, column c, tagged with its
// row and column; interior bytes carry the truncated mean of the left, right,
// upper and lower neighbours in the same channel, border bytes carry zero. The
// first row produces nothing, the last row produces two words per input (the
// row above, then its own zero byte, the final one flagged by out_last).
// A result word passes through the filter stage and the result queue before it is offered.
// Throughput: one sample per cycle while the result queue has room, set by the single
// registered pass from the line store read to the result queue; in the last row, where each
// sample makes two words, the result port, which moves one word per cycle, holds samples back.
// The user must write geometry through the APB port only while the block is idle; the block
// itself does not enforce this. A write restarts the frame. Reset sets 640 x 480 with one
// channel, empties all queues and needs no clearing pass over the line store.
// When the receiver stalls, a four-word result queue absorbs the backlog; once the queue
// cannot take two more words, the filter stage holds and the samples channel drops ready.
module four_neighbour_mean_filter import fnm_pkg::*; #(
  parameter int MAX_WIDTH = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int MAX_CHANNELS = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  fnm_sample_if.sink            samples,
  fnm_result_if.source          results,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  // Geometry derived from the maximum image size.
  localparam int LINE_BYTES = MAX_WIDTH * MAX_CHANNELS;
  localparam int CW = $clog2(LINE_BYTES);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int MEM_DEPTH = 2 * (2 ** CW);
  localparam int AW = CW + 1;
  localparam int FW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int TAPS = 2 * MAX_CHANNELS;
  localparam int TW = $clog2(TAPS);

  // Configuration registers.
  logic [CFG_DIM_W-1:0] image_width;
  logic [CFG_DIM_W-1:0] image_height;
  logic [CFG_CH_W-1:0]  channel_count;
  logic [1:0]           cfg_idx;
  logic                 cfg_wr;
  logic                 cfg_restart;

  assign pready = 1'b1;
  assign cfg_idx = paddr[APB_ADDR_W-1:2];
  assign cfg_wr = psel && penable && pwrite;
  assign cfg_restart = cfg_wr && (cfg_idx == REG_WIDTH || cfg_idx == REG_HEIGHT ||
                                  cfg_idx == REG_CHANNELS);

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
      channel_count <= CHANNELS_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_WIDTH: image_width <= pwdata[CFG_DIM_W-1:0];
        REG_HEIGHT: image_height <= pwdata[CFG_DIM_W-1:0];
        REG_CHANNELS: channel_count <= pwdata[CFG_CH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_WIDTH: prdata = APB_DATA_W'(image_width);
      REG_HEIGHT: prdata = APB_DATA_W'(image_height);
      REG_CHANNELS: prdata = APB_DATA_W'(channel_count);
      default: prdata = '0;
    endcase
  end

  // Register values are saturated into the supported range when used.
  logic [31:0] w_raw, h_raw, ch_raw;
  logic [31:0] w_eff, h_eff, ch_eff, bytes_per_row;

  always_comb begin
    w_raw = 32'(image_width);
    h_raw = 32'(image_height);
    ch_raw = 32'(channel_count);
    if (w_raw < 32'(DIM_MIN)) begin
      w_eff = 32'(DIM_MIN);
    end else if (w_raw > 32'(MAX_WIDTH)) begin
      w_eff = 32'(MAX_WIDTH);
    end else begin
      w_eff = w_raw;
    end
    if (h_raw < 32'(DIM_MIN)) begin
      h_eff = 32'(DIM_MIN);
    end else if (h_raw > 32'(MAX_HEIGHT)) begin
      h_eff = 32'(MAX_HEIGHT);
    end else begin
      h_eff = h_raw;
    end
    if (ch_raw < 32'(CH_MIN)) begin
      ch_eff = 32'(CH_MIN);
    end else if (ch_raw > 32'(MAX_CHANNELS)) begin
      ch_eff = 32'(MAX_CHANNELS);
    end else begin
      ch_eff = ch_raw;
    end
    bytes_per_row = w_eff * ch_eff;
  end

  // Input side: position counters, line store addressing and border decisions.
  logic [RW-1:0] row_count, row_count_next;
  logic [CW-1:0] col_count, col_count_next;
  logic          out_of_range;
  logic [RW-1:0] r0;
  logic [CW-1:0] c0;
  logic [31:0]   c_plus, c_inc, r_inc;
  logic          accept;
  logic          advance;
  logic [AW-1:0] up_addr, mid_addr;

  assign accept = samples.valid && samples.ready;

  always_comb begin
    out_of_range = (32'(row_count) >= h_eff) || (32'(col_count) >= bytes_per_row);
    r0 = out_of_range ? '0 : row_count;
    c0 = out_of_range ? '0 : col_count;
    c_plus = 32'(c0) + ch_eff;
    c_inc = 32'(c0) + 32'd1;
    r_inc = 32'(r0) + 32'd1;
    // The upper row shares its bank with the row being written now.
    up_addr = {r0[0], c0};
    mid_addr = {~r0[0], c_plus[CW-1:0]};
    if (c_inc >= bytes_per_row) begin
      col_count_next = '0;
      row_count_next = (r_inc >= h_eff) ? '0 : r_inc[RW-1:0];
    end else begin
      col_count_next = c_inc[CW-1:0];
      row_count_next = r0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_restart) begin
      row_count <= '0;
      col_count <= '0;
    end else if (accept) begin
      row_count <= row_count_next;
      col_count <= col_count_next;
    end
  end

  // Filter stage: one item, with the line store words read for it.
  logic                v1;
  logic [SAMPLE_W-1:0] s1_sample;
  logic [RW-1:0]       s1_row;
  logic [CW-1:0]       s1_col;
  logic                s1_emit_up;
  logic                s1_emit_last;
  logic                s1_interior;
  logic                s1_last_byte;
  logic                s1_par;
  logic [AW-1:0]       s1_waddr;
  logic                s1_fw_en;
  logic [FW-1:0]       s1_fw_idx;
  logic [FW-1:0]       s1_fr_idx;
  logic                s1_use_first;
  logic [TW-1:0]       s1_tap;
  logic [31:0]         c_minus;
  logic [31:0]         tap_sel;
  logic [FIFO_CNT_W-1:0] fifo_count;

  assign advance = v1 && (fifo_count <= FIFO_CNT_W'(FIFO_DEPTH - 2));
  assign samples.ready = !v1 || advance;
  assign c_minus = 32'(c0) - ch_eff;
  assign tap_sel = 32'd2 * ch_eff - 32'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (accept) begin
      v1 <= 1'b1;
    end else if (advance) begin
      v1 <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_sample <= samples.sample;
      s1_row <= r0;
      s1_col <= c0;
      s1_emit_up <= (r0 != '0);
      s1_emit_last <= (32'(r0) == h_eff - 32'd1);
      s1_interior <= (32'(r0) >= 32'd2) && (32'(c0) >= ch_eff) && (c_plus < bytes_per_row);
      s1_last_byte <= (32'(c0) == bytes_per_row - 32'd1);
      s1_par <= r0[0];
      s1_waddr <= up_addr;
      s1_fw_en <= (32'(c0) < ch_eff);
      s1_fw_idx <= c0[FW-1:0];
      s1_fr_idx <= c_minus[FW-1:0];
      s1_use_first <= (32'(c0) < 32'd2 * ch_eff);
      s1_tap <= tap_sel[TW-1:0];
    end
  end

  // Line store: two banks of one row each, chosen by row parity.
  logic [SAMPLE_W-1:0] rd_up, rd_mid;

  fnm_ram #(
    .DATA_W(SAMPLE_W),
    .DEPTH(MEM_DEPTH)
  ) u_line_store (
    .clk(clk),
    .we(advance),
    .waddr(s1_waddr),
    .wdata(s1_sample),
    .re(accept),
    .raddr_a(up_addr),
    .raddr_b(mid_addr),
    .rdata_a(rd_up),
    .rdata_b(rd_mid)
  );

  // The right neighbour is read ahead; the left one comes back out of a short
  // shift line of those reads, or, near the row start, from a copy of the
  // previous row's first pixel.
  logic [SAMPLE_W-1:0] mid_line [TAPS];
  logic [SAMPLE_W-1:0] first_bytes [2][MAX_CHANNELS];

  always_ff @(posedge clk) begin
    if (advance) begin
      mid_line[0] <= rd_mid;
      for (int i = 1; i < TAPS; i++) begin
        mid_line[i] <= mid_line[i-1];
      end
      if (s1_fw_en) begin
        first_bytes[s1_par][s1_fw_idx] <= s1_sample;
      end
    end
  end

  logic [SAMPLE_W-1:0] left_byte;
  logic [SAMPLE_W+1:0] sum4;
  logic [RW-1:0]       row_above;
  result_t             up_res, last_res, first_res;
  logic [1:0]          push_n;
  logic                pop;

  always_comb begin
    left_byte = s1_use_first ? first_bytes[~s1_par][s1_fr_idx] : mid_line[s1_tap];
    sum4 = (SAMPLE_W + 2)'(rd_up) + (SAMPLE_W + 2)'(left_byte) +
           (SAMPLE_W + 2)'(rd_mid) + (SAMPLE_W + 2)'(s1_sample);
    row_above = s1_row - 1'b1;
    up_res.out_value = s1_interior ? sum4[SAMPLE_W+1:2] : '0;
    up_res.out_row = ROW_W'(row_above);
    up_res.out_col = COL_W'(s1_col);
    up_res.out_last = 1'b0;
    last_res.out_value = '0;
    last_res.out_row = ROW_W'(s1_row);
    last_res.out_col = COL_W'(s1_col);
    last_res.out_last = s1_last_byte;
    first_res = s1_emit_up ? up_res : last_res;
    push_n = advance ? ({1'b0, s1_emit_up} + {1'b0, s1_emit_last}) : 2'd0;
  end

  // Result queue.
  result_t               fifo_mem [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr, rd_ptr;
  result_t               head;

  assign pop = results.valid && results.ready;
  assign head = fifo_mem[rd_ptr];
  assign results.valid = (fifo_count != '0);
  assign results.out_value = head.out_value;
  assign results.out_row = head.out_row;
  assign results.out_col = head.out_col;
  assign results.out_last = head.out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fifo_count <= '0;
    end else begin
      wr_ptr <= wr_ptr + FIFO_PTR_W'(push_n);
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      fifo_count <= fifo_count + FIFO_CNT_W'(push_n) - FIFO_CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      fifo_mem[wr_ptr] <= first_res;
    end
    if (push_n == 2'd2) begin
      fifo_mem[wr_ptr + 1'b1] <= last_res;
    end
  end

  // Checks.
  a_fifo_bound: assert property (@(posedge clk) disable iff (rst)
    fifo_count <= FIFO_CNT_W'(FIFO_DEPTH))
    else $error("result queue overfilled");

  a_accept_loads: assert property (@(posedge clk) disable iff (rst)
    accept |=> v1)
    else $error("accepted word did not reach the filter stage");

  a_last_row_pair: assert property (@(posedge clk) disable iff (rst)
    v1 && s1_emit_last |-> s1_emit_up)
    else $error("last row word without the word of the row above");

  a_last_is_border: assert property (@(posedge clk) disable iff (rst)
    results.valid && results.out_last |-> results.out_value == '0)
    else $error("final word of the frame is not a border zero");

  a_cfg_restart: assert property (@(posedge clk) disable iff (rst)
    cfg_restart |=> row_count == '0 && col_count == '0)
    else $error("register write did not restart the frame");

endmodule
